/* src/cdt_pkg.sv */
// Shared types and constants of the conditional directive tracker.
package cdt_pkg;

    localparam int MAX_NEST_DEF = 16;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [2:0] {
        OP_IFDEF  = 3'd0,
        OP_IFNDEF = 3'd1,
        OP_ELSIF  = 3'd2,
        OP_ELSE   = 3'd3,
        OP_ENDIF  = 3'd4,
        OP_RESET  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SYNTAX = 3'd1,
        ST_DUP    = 3'd2,
        ST_UNBAL  = 3'd3,
        ST_OVER   = 3'd4
    } t_status;

    // what a stack cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_SHIFT_OUT,
        CELL_CLEAR
    } t_cell_op;

    // per-level bits held in one cell
    typedef struct packed {
        logic else_seen;
        logic taken;
    } t_level;

    typedef struct packed {
        t_status status;
        logic    active;
    } t_result;

endpackage

/* src/cdt_cell.sv */
// One level of the nesting stack: takes its neighbor's bits on push or pop, or clears them.
module cdt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdt_pkg::t_cell_op i_op,
    input  cdt_pkg::t_level   i_shallow,
    input  cdt_pkg::t_level   i_deep,
    output cdt_pkg::t_level   o_level
);

    cdt_pkg::t_level r_level;
    cdt_pkg::t_level n_level;

    always_comb begin
        case (i_op)
            cdt_pkg::CELL_SHIFT_IN:  n_level = i_shallow;
            cdt_pkg::CELL_SHIFT_OUT: n_level = i_deep;
            cdt_pkg::CELL_CLEAR:     n_level = '0;
            default:                 n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

/* src/conditional_directive_tracker_unit.sv */
// Top level of the conditional directive tracker: control, stack of cells, output stage.
//
// One directive is taken per cycle while the skid entry is empty; its result (status,
// active flag) goes to the output register; a one-entry skid stage lets the next directive
// be taken while a result waits, so throughput is one item per cycle until it fills.
// The per-level else-seen and taken bits live in a row of MAX_NEST cells that
// shift one step deeper on ifdef/ifndef and one step back on endif, with the current
// level always in the first cell; the active flag and the two depth counters are updated
// as each directive is taken, which sets the rate.
module conditional_directive_tracker_unit #(
    parameter int MAX_NEST = cdt_pkg::MAX_NEST_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [2:0] operation, [3] macro_defined, [4] syntax_ok, [7:5] zero
    input  logic [cdt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [2:0] status, [3] active, [7:4] zero
    output logic [cdt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int LW = $clog2(MAX_NEST + 1);
    localparam logic [LW-1:0] MAX_LVL = LW'(MAX_NEST);

    logic            w_accept;
    logic [2:0]      w_op;
    logic            w_def;
    logic            w_syn;

    logic            r_active;
    logic [LW-1:0]   r_live;
    logic [LW-1:0]   r_dead;
    logic            n_active;
    logic [LW-1:0]   n_live;
    logic [LW-1:0]   n_dead;
    logic [LW-1:0]   w_lvl;
    logic            w_top_es;
    logic            w_top_tk;
    logic            w_cond;

    cdt_pkg::t_cell_op w_stack_op;
    logic              w_top_only;
    cdt_pkg::t_level   w_new_top;
    cdt_pkg::t_status  w_status;
    cdt_pkg::t_level   w_cells [MAX_NEST];

    cdt_pkg::t_result r_out;
    cdt_pkg::t_result n_out;
    cdt_pkg::t_result r_skid;
    cdt_pkg::t_result n_skid;
    cdt_pkg::t_result w_res;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_skid_valid;
    logic             n_skid_valid;
    logic             w_take;

    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op  = i_s_axis_tdata[2:0];
    assign w_def = i_s_axis_tdata[3];
    assign w_syn = i_s_axis_tdata[4];

    assign w_lvl    = r_live + r_dead;
    assign w_top_es = (w_lvl != '0) && w_cells[0].else_seen;
    assign w_top_tk = (w_lvl != '0) && w_cells[0].taken;
    assign w_cond   = (w_op == cdt_pkg::OP_IFNDEF) ? !w_def : w_def;

    always_comb begin
        n_active   = r_active;
        n_live     = r_live;
        n_dead     = r_dead;
        w_status   = cdt_pkg::ST_OK;
        w_stack_op = cdt_pkg::CELL_HOLD;
        w_top_only = 1'b0;
        w_new_top  = '0;
        unique case (w_op) inside
            cdt_pkg::OP_IFDEF, cdt_pkg::OP_IFNDEF: begin
                if (!w_syn) begin
                    w_status = cdt_pkg::ST_SYNTAX;
                end else if (w_lvl >= MAX_LVL) begin
                    w_status = cdt_pkg::ST_OVER;
                end else begin
                    w_stack_op = cdt_pkg::CELL_SHIFT_IN;
                    if (r_active) begin
                        n_live          = r_live + LW'(1);
                        n_active        = w_cond;
                        w_new_top.taken = w_cond;
                    end else begin
                        n_dead = r_dead + LW'(1);
                    end
                end
            end
            cdt_pkg::OP_ELSIF: begin
                if (w_top_es) begin
                    w_status = cdt_pkg::ST_DUP;
                end else if (!w_syn) begin
                    w_status = cdt_pkg::ST_SYNTAX;
                end else if (w_lvl == '0) begin
                    w_status = cdt_pkg::ST_UNBAL;
                end else if (r_dead == '0) begin
                    if (w_top_tk) begin
                        n_active = 1'b0;
                    end else begin
                        n_active        = w_def;
                        w_stack_op      = cdt_pkg::CELL_SHIFT_IN;
                        w_top_only      = 1'b1;
                        w_new_top.taken = w_def;
                    end
                end
            end
            cdt_pkg::OP_ELSE: begin
                if (w_top_es) begin
                    w_status = cdt_pkg::ST_DUP;
                end else if (!w_syn) begin
                    w_status = cdt_pkg::ST_SYNTAX;
                end else if (w_lvl == '0) begin
                    w_status = cdt_pkg::ST_UNBAL;
                end else begin
                    w_stack_op          = cdt_pkg::CELL_SHIFT_IN;
                    w_top_only          = 1'b1;
                    w_new_top.else_seen = 1'b1;
                    w_new_top.taken     = w_top_tk;
                    if (r_dead == '0) begin
                        n_active        = !w_top_tk;
                        w_new_top.taken = 1'b1;
                    end
                end
            end
            cdt_pkg::OP_ENDIF: begin
                if (!w_syn) begin
                    w_status = cdt_pkg::ST_SYNTAX;
                end else if (w_lvl == '0) begin
                    w_status = cdt_pkg::ST_UNBAL;
                end else begin
                    w_stack_op = cdt_pkg::CELL_SHIFT_OUT;
                    if (r_dead != '0) begin
                        n_dead = r_dead - LW'(1);
                    end else begin
                        n_live   = r_live - LW'(1);
                        n_active = 1'b1;
                    end
                end
            end
            cdt_pkg::OP_RESET: begin
                w_stack_op = cdt_pkg::CELL_CLEAR;
                n_active   = 1'b1;
                n_live     = '0;
                n_dead     = '0;
            end
            default: begin
            end
        endcase
        if (!w_accept) begin
            w_stack_op = cdt_pkg::CELL_HOLD;
            w_top_only = 1'b0;
        end
    end

    assign w_res.status = w_status;
    assign w_res.active = n_active;

    // stack of per-level bits; cell 0 is the current level
    for (genvar g = 0; g < MAX_NEST; g++) begin : g_cell
        cdt_pkg::t_cell_op w_op_g;
        cdt_pkg::t_level   w_shallow;
        cdt_pkg::t_level   w_deep;
        if (g == 0) begin : g_first
            assign w_shallow = w_new_top;
            assign w_op_g    = w_stack_op;
        end else begin : g_rest
            assign w_shallow = w_cells[g-1];
            assign w_op_g    = w_top_only ? cdt_pkg::CELL_HOLD : w_stack_op;
        end
        if (g == MAX_NEST - 1) begin : g_last
            assign w_deep = '0;
        end else begin : g_inner
            assign w_deep = w_cells[g+1];
        end
        cdt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_op      (w_op_g),
            .i_shallow (w_shallow),
            .i_deep    (w_deep),
            .o_level   (w_cells[g])
        );
    end

    // output register plus skid entry
    assign w_take = r_out_valid && i_m_axis_tready;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_res;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b1;
            r_live       <= '0;
            r_dead       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_active <= n_active;
                r_live   <= n_live;
                r_dead   <= n_dead;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.active, r_out.status};

endmodule
